>>> src/assert_macros.svh
// Assertion macros for the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, switched off while rst_n is low
`define CLLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, written as an implication from a condition to a consequence
`define CLLE_ASSERT_IMP(lbl, ante, cons, msg) \
    `CLLE_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> src/clle_pkg.sv
// Shared constants, types and codes of the cursor linked list engine
package clle_pkg;

    localparam int POOL_NODES   = 256;
    localparam int NODE_BITS    = $clog2(POOL_NODES);
    localparam int LINK_BITS    = NODE_BITS + 1;
    localparam int COUNT_BITS   = $clog2(POOL_NODES + 1);

    localparam int MODE_BITS    = 4;
    localparam int HANDLE_BITS  = 8;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int INDEX_BITS   = 8;
    localparam int TOTAL_BITS   = 9;
    localparam int DATA_BITS    = KEY_BITS + PAYLOAD_BITS;

    typedef logic [LINK_BITS-1:0] link_t;
    typedef logic [NODE_BITS-1:0] node_t;

    localparam link_t NONE_NODE = LINK_BITS'(POOL_NODES);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_INS_AFTER  = 4'd0,
        MODE_INS_BEFORE = 4'd1,
        MODE_REM_CURSOR = 4'd2,
        MODE_REM_HANDLE = 4'd3,
        MODE_SELECT     = 4'd4,
        MODE_PREV       = 4'd5,
        MODE_NEXT       = 4'd6,
        MODE_FIRST      = 4'd7,
        MODE_LAST       = 4'd8,
        MODE_READ       = 4'd9
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC,
        ST_FIX,
        ST_RESULT
    } state_t;

    // Request as taken from the input stream
    typedef struct packed {
        logic [MODE_BITS-1:0]    mode;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [KEY_BITS-1:0]     key;
        logic [HANDLE_BITS-1:0]  handle;
    } request_t;

    // Result; the last member sits in the lowest bits
    typedef struct packed {
        logic [TOTAL_BITS-1:0]   node_total;
        logic [PAYLOAD_BITS-1:0] cursor_payload;
        logic [KEY_BITS-1:0]     cursor_key;
        logic [INDEX_BITS-1:0]   cursor_index;
        logic                    cursor_present;
        logic                    ok;
    } result_t;

    localparam int IN_DATA_BITS   = PAYLOAD_BITS + KEY_BITS + HANDLE_BITS;
    localparam int IN_TDATA_BITS  = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int RESULT_BITS    = $bits(result_t);
    localparam int OUT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

>>> src/clle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data
module clle_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/clle_seq.sv
// Operation sequencer: node memories, list registers and read-modify-write steps
module clle_seq
    import clle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  request_t req,
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  res
);

    state_t                  state_reg, state_next;
    request_t                req_reg, req_next;
    link_t                   cursor_reg, cursor_next;
    link_t                   first_reg, first_next;
    link_t                   last_reg, last_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [COUNT_BITS-1:0]   depth_reg, depth_next;
    logic [COUNT_BITS-1:0]   fresh_reg, fresh_next;
    logic [POOL_NODES-1:0]   live_reg, live_next;
    logic                    ok_reg, ok_next;
    link_t                   at_reg, at_next;
    logic                    before_reg, before_next;
    node_t                   node_reg, node_next;

    logic                    nl_we, pl_we, lk_re;
    node_t                   nl_waddr, pl_waddr, lk_raddr;
    link_t                   nl_wdata, pl_wdata, nl_q, pl_q;
    logic                    dm_we, dm_re;
    node_t                   dm_waddr, dm_raddr;
    logic [DATA_BITS-1:0]    dm_wdata, dm_q;
    logic                    fs_we, fs_re;
    node_t                   fs_waddr, fs_raddr;
    node_t                   fs_wdata, fs_q;

    mode_t                   op;
    link_t                   hdl_link;
    link_t                   new_cur;
    logic                    cur_ok, has_p, has_x, has_free, has_fresh;

    function automatic logic node_valid(input logic [POOL_NODES-1:0] live, input link_t n);
        logic in_range;
        in_range = (n < LINK_BITS'(POOL_NODES));
        return in_range && live[n[NODE_BITS-1:0]];
    endfunction

    clle_ram #(.DEPTH(POOL_NODES), .WIDTH(LINK_BITS)) u_next_ram (
        .clk   (clk),
        .we    (nl_we),
        .waddr (nl_waddr),
        .wdata (nl_wdata),
        .re    (lk_re),
        .raddr (lk_raddr),
        .rdata (nl_q)
    );

    clle_ram #(.DEPTH(POOL_NODES), .WIDTH(LINK_BITS)) u_prev_ram (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .re    (lk_re),
        .raddr (lk_raddr),
        .rdata (pl_q)
    );

    clle_ram #(.DEPTH(POOL_NODES), .WIDTH(DATA_BITS)) u_data_ram (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (dm_re),
        .raddr (dm_raddr),
        .rdata (dm_q)
    );

    clle_ram #(.DEPTH(POOL_NODES), .WIDTH(NODE_BITS)) u_free_ram (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .re    (fs_re),
        .raddr (fs_raddr),
        .rdata (fs_q)
    );

    assign op        = mode_t'(req_reg.mode);
    assign hdl_link  = (32'(req_reg.handle) < POOL_NODES) ? LINK_BITS'(req_reg.handle)
                                                          : NONE_NODE;
    assign cur_ok    = node_valid(live_reg, cursor_reg);
    assign has_free  = (depth_reg != '0);
    assign has_fresh = (fresh_reg < COUNT_BITS'(POOL_NODES));
    assign has_p     = node_valid(live_reg, pl_q);
    assign has_x     = node_valid(live_reg, nl_q);
    assign new_cur   = has_x ? nl_q : (has_p ? pl_q : NONE_NODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cursor_reg <= NONE_NODE;
            first_reg  <= NONE_NODE;
            last_reg   <= NONE_NODE;
            count_reg  <= '0;
            depth_reg  <= '0;
            fresh_reg  <= '0;
            live_reg   <= '0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            first_reg  <= first_next;
            last_reg   <= last_next;
            count_reg  <= count_next;
            depth_reg  <= depth_next;
            fresh_reg  <= fresh_next;
            live_reg   <= live_next;
            ok_reg     <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        at_reg     <= at_next;
        before_reg <= before_next;
        node_reg   <= node_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        cursor_next = cursor_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        depth_next  = depth_reg;
        fresh_next  = fresh_reg;
        live_next   = live_reg;
        ok_next     = ok_reg;
        at_next     = at_reg;
        before_next = before_reg;
        node_next   = node_reg;

        req_ready   = 1'b0;
        res_valid   = 1'b0;

        nl_we    = 1'b0;
        nl_waddr = '0;
        nl_wdata = NONE_NODE;
        pl_we    = 1'b0;
        pl_waddr = '0;
        pl_wdata = NONE_NODE;
        lk_re    = 1'b0;
        lk_raddr = '0;
        dm_we    = 1'b0;
        dm_waddr = node_reg;
        dm_wdata = {req_reg.key, req_reg.payload};
        dm_re    = 1'b0;
        dm_raddr = cursor_reg[NODE_BITS-1:0];
        fs_we    = 1'b0;
        fs_waddr = depth_reg[NODE_BITS-1:0];
        fs_wdata = at_reg[NODE_BITS-1:0];
        fs_re    = 1'b0;
        fs_raddr = NODE_BITS'(depth_reg - COUNT_BITS'(1));

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = ST_LOOK;
                end
            end

            // Decide and issue the first reads
            ST_LOOK:
            begin
                ok_next    = 1'b0;
                dm_re      = 1'b1;
                state_next = ST_RESULT;
                unique case (op)
                    MODE_INS_AFTER, MODE_INS_BEFORE:
                    begin
                        if (has_free || has_fresh)
                        begin
                            fs_re       = has_free;
                            at_next     = cur_ok ? cursor_reg : last_reg;
                            before_next = cur_ok && (op == MODE_INS_BEFORE);
                            lk_re       = 1'b1;
                            lk_raddr    = at_next[NODE_BITS-1:0];
                            dm_re       = 1'b0;
                            state_next  = ST_EXEC;
                        end
                    end
                    MODE_REM_CURSOR, MODE_REM_HANDLE:
                    begin
                        at_next = (op == MODE_REM_CURSOR) ? cursor_reg : hdl_link;
                        if (node_valid(live_reg, at_next))
                        begin
                            lk_re      = 1'b1;
                            lk_raddr   = at_next[NODE_BITS-1:0];
                            dm_re      = 1'b0;
                            state_next = ST_EXEC;
                        end
                    end
                    MODE_PREV, MODE_NEXT:
                    begin
                        if (cur_ok)
                        begin
                            lk_re      = 1'b1;
                            lk_raddr   = cursor_reg[NODE_BITS-1:0];
                            dm_re      = 1'b0;
                            state_next = ST_EXEC;
                        end
                    end
                    MODE_SELECT:
                    begin
                        if (node_valid(live_reg, hdl_link))
                        begin
                            cursor_next = hdl_link;
                            ok_next     = 1'b1;
                            dm_raddr    = hdl_link[NODE_BITS-1:0];
                        end
                    end
                    MODE_FIRST:
                    begin
                        cursor_next = node_valid(live_reg, first_reg) ? first_reg : NONE_NODE;
                        ok_next     = node_valid(live_reg, first_reg);
                        dm_raddr    = first_reg[NODE_BITS-1:0];
                    end
                    MODE_LAST:
                    begin
                        cursor_next = node_valid(live_reg, last_reg) ? last_reg : NONE_NODE;
                        ok_next     = node_valid(live_reg, last_reg);
                        dm_raddr    = last_reg[NODE_BITS-1:0];
                    end
                    MODE_READ:
                    begin
                        ok_next = cur_ok;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end

            // Link read data is back: write the new node, or unlink, or step
            ST_EXEC:
            begin
                dm_re      = 1'b1;
                state_next = ST_RESULT;
                unique case (op)
                    MODE_INS_AFTER, MODE_INS_BEFORE:
                    begin
                        dm_re = 1'b0;
                        if (has_free)
                        begin
                            node_next  = fs_q;
                            depth_next = depth_reg - COUNT_BITS'(1);
                        end
                        else
                        begin
                            node_next  = fresh_reg[NODE_BITS-1:0];
                            fresh_next = fresh_reg + COUNT_BITS'(1);
                        end
                        dm_we    = 1'b1;
                        dm_waddr = node_next;
                        nl_we    = 1'b1;
                        nl_waddr = node_next;
                        pl_we    = 1'b1;
                        pl_waddr = node_next;
                        if (!node_valid(live_reg, at_reg))
                        begin
                            nl_wdata = NONE_NODE;
                            pl_wdata = NONE_NODE;
                        end
                        else if (!before_reg)
                        begin
                            pl_wdata = at_reg;
                            nl_wdata = nl_q;
                        end
                        else
                        begin
                            nl_wdata = at_reg;
                            pl_wdata = pl_q;
                        end
                        state_next = ST_FIX;
                    end
                    MODE_REM_CURSOR, MODE_REM_HANDLE:
                    begin
                        nl_we    = has_p;
                        nl_waddr = pl_q[NODE_BITS-1:0];
                        nl_wdata = nl_q;
                        if (!has_p)
                        begin
                            first_next = has_x ? nl_q : NONE_NODE;
                        end
                        pl_we    = has_x;
                        pl_waddr = nl_q[NODE_BITS-1:0];
                        pl_wdata = pl_q;
                        if (!has_x)
                        begin
                            last_next = has_p ? pl_q : NONE_NODE;
                        end
                        cursor_next = new_cur;
                        dm_raddr    = new_cur[NODE_BITS-1:0];
                        live_next[at_reg[NODE_BITS-1:0]] = 1'b0;
                        if (depth_reg != COUNT_BITS'(POOL_NODES))
                        begin
                            fs_we      = 1'b1;
                            depth_next = depth_reg + COUNT_BITS'(1);
                        end
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - COUNT_BITS'(1);
                        end
                        ok_next = 1'b1;
                    end
                    MODE_PREV:
                    begin
                        if (has_p)
                        begin
                            cursor_next = pl_q;
                            dm_raddr    = pl_q[NODE_BITS-1:0];
                            ok_next     = 1'b1;
                        end
                    end
                    MODE_NEXT:
                    begin
                        if (has_x)
                        begin
                            cursor_next = nl_q;
                            dm_raddr    = nl_q[NODE_BITS-1:0];
                            ok_next     = 1'b1;
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end

            // Insert only: patch the neighbors and take the new node live
            ST_FIX:
            begin
                if (!node_valid(live_reg, at_reg))
                begin
                    first_next = LINK_BITS'(node_reg);
                    last_next  = LINK_BITS'(node_reg);
                end
                else if (!before_reg)
                begin
                    nl_we    = 1'b1;
                    nl_waddr = at_reg[NODE_BITS-1:0];
                    nl_wdata = LINK_BITS'(node_reg);
                    if (has_x)
                    begin
                        pl_we    = 1'b1;
                        pl_waddr = nl_q[NODE_BITS-1:0];
                        pl_wdata = LINK_BITS'(node_reg);
                    end
                    else
                    begin
                        last_next = LINK_BITS'(node_reg);
                    end
                end
                else
                begin
                    pl_we    = 1'b1;
                    pl_waddr = at_reg[NODE_BITS-1:0];
                    pl_wdata = LINK_BITS'(node_reg);
                    if (has_p)
                    begin
                        nl_we    = 1'b1;
                        nl_waddr = pl_q[NODE_BITS-1:0];
                        nl_wdata = LINK_BITS'(node_reg);
                    end
                    else
                    begin
                        first_next = LINK_BITS'(node_reg);
                    end
                end
                live_next[node_reg] = 1'b1;
                cursor_next = LINK_BITS'(node_reg);
                count_next  = count_reg + COUNT_BITS'(1);
                ok_next     = 1'b1;
                dm_re       = 1'b1;
                dm_raddr    = node_reg;
                state_next  = ST_RESULT;
            end

            // Hold the result until the output register takes it
            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.ok             = ok_reg;
        res.cursor_present = cur_ok;
        res.cursor_index   = cur_ok ? INDEX_BITS'(cursor_reg[NODE_BITS-1:0]) : '0;
        res.cursor_key     = cur_ok ? dm_q[DATA_BITS-1:PAYLOAD_BITS] : '0;
        res.cursor_payload = cur_ok ? dm_q[PAYLOAD_BITS-1:0] : '0;
        res.node_total     = TOTAL_BITS'(count_reg);
    end

endmodule

>>> src/clle_obuf.sv
// Output register between the sequencer and the result stream
module clle_obuf
    import clle_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_valid,
    output logic    res_ready,
    input  result_t res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_valid && res_ready)
        begin
            valid_next = 1'b1;
            data_next  = res;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

>>> src/cursor_linked_list_engine_core.sv
// Top level of the cursor linked list engine
//
//  channel   dir  tdata (lowest bit up)                          tuser
//  s_axis    in   handle[7:0] key[31:0] payload[31:0]            mode[3:0]
//  m_axis    out  ok present index[7:0] key[31:0] payload[31:0]  -
//                 node_total[8:0], zero fill to 88 bits
//
//  One request at a time. Select, first, last, read and requests refused
//  before any link read go from look straight to result; prev, next
//  and remove that go on to read the links pass through exec, insert
//  through exec and fix; the registered link RAM reads set these steps.
//  rst_n empties the list at once: node live flags sit in flip-flops, so no
//  clearing pass runs. A stalled m_axis holds one result in the output
//  register while the next request is already taken in and worked on.
module cursor_linked_list_engine_core
    import clle_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // handle, key, payload
    input  logic [MODE_BITS-1:0]      s_axis_tuser,   // mode
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata    // ok, present, index, key,
                                                      // payload, node_total
);

    request_t req;
    result_t  seq_res;
    result_t  out_res;
    logic     res_valid;
    logic     res_ready;

    // Unpack the request transfer
    assign req.mode    = s_axis_tuser;
    assign req.handle  = s_axis_tdata[HANDLE_BITS-1:0];
    assign req.key     = s_axis_tdata[HANDLE_BITS +: KEY_BITS];
    assign req.payload = s_axis_tdata[HANDLE_BITS + KEY_BITS +: PAYLOAD_BITS];

    // Sequencer owns the node RAMs, free stack and list registers
    clle_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (seq_res)
    );

    // Output register parts the sequencer from the result stream
    clle_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (seq_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Zero fill the result to whole bytes
    assign m_axis_tdata = OUT_TDATA_BITS'(out_res);

endmodule

>>> src/clle_chk.sv
// Port-level checker for the cursor linked list engine, bound to the top level
`include "assert_macros.svh"

module clle_chk
    import clle_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

    result_t r;
    logic    in_xfer;
    logic    out_wait;
    logic    no_cursor;
    logic    fields_zero;
    logic    count_ok;
    logic    fill_zero;

    assign r           = m_axis_tdata[RESULT_BITS-1:0];
    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign out_wait    = m_axis_tvalid && !m_axis_tready;
    assign no_cursor   = m_axis_tvalid && !r.cursor_present;
    assign fields_zero = (r.cursor_index == '0) && (r.cursor_key == '0) &&
                         (r.cursor_payload == '0);
    assign count_ok    = (r.node_total <= TOTAL_BITS'(POOL_NODES)) &&
                         (!r.cursor_present || (r.node_total != '0));
    assign fill_zero   = (m_axis_tdata[OUT_TDATA_BITS-1:RESULT_BITS] == '0);

    // A stalled result holds its valid and data
    `CLLE_ASSERT_IMP(a_out_hold, out_wait, ##1 (m_axis_tvalid && $stable(r)), "stall lost")

    // One request at a time: ready drops after a transfer
    `CLLE_ASSERT_IMP(a_one_at_a_time, in_xfer, ##1 !s_axis_tready, "taken while busy")

    // No cursor means index, key and payload read as zero
    `CLLE_ASSERT_IMP(a_no_cursor_zero, no_cursor, fields_zero, "stale cursor fields")

    // A cursor on a node needs a non-empty list, never more than the pool
    `CLLE_ASSERT_IMP(a_count_sane, m_axis_tvalid, count_ok, "node count out of line")

    // Fill bits above the result stay zero
    `CLLE_ASSERT_IMP(a_fill_zero, m_axis_tvalid, fill_zero, "fill bits set")

endmodule

bind cursor_linked_list_engine_core clle_chk u_clle_chk (.*);

>>> tb/tb_top.sv
// Testbench for the cursor linked list engine, checked against a local list model
`timescale 1ns / 1ps

module tb_top;
    import clle_pkg::*;

    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 20;

    typedef struct packed {
        logic [MODE_BITS-1:0]    mode;
        logic [HANDLE_BITS-1:0]  handle;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } list_req_t;

    logic                      clk;
    logic                      rst_n         = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    logic [MODE_BITS-1:0]      s_axis_tuser  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    list_req_t pending_reqs[$];
    result_t   expected_results[$];

    int offered_count      = 0;
    int taken_count        = 0;
    int results_seen       = 0;
    int mismatch_count     = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;
    int hold_seen          = 0;
    int hold_left          = 0;

    // List model state
    link_t                   succ_link     [POOL_NODES];
    link_t                   pred_link     [POOL_NODES];
    logic [KEY_BITS-1:0]     key_store     [POOL_NODES];
    logic [PAYLOAD_BITS-1:0] payload_store [POOL_NODES];
    bit                      in_use        [POOL_NODES];
    link_t                   spare_stack   [POOL_NODES];
    int                      spare_depth = 0;
    int                      fresh_next  = 0;
    link_t                   list_head   = NONE_NODE;
    link_t                   list_tail   = NONE_NODE;
    link_t                   cursor_at   = NONE_NODE;
    int                      node_count  = 0;

    cursor_linked_list_engine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic bit is_live(link_t n);
        if (n >= NONE_NODE)
        begin
            return 1'b0;
        end
        return in_use[n];
    endfunction

    function automatic bit insert_node(bit before_cur, logic [KEY_BITS-1:0] k,
                                       logic [PAYLOAD_BITS-1:0] v);
        link_t n;
        link_t at;
        link_t nb;
        if (spare_depth > 0)
        begin
            spare_depth--;
            n = spare_stack[spare_depth];
        end
        else if (fresh_next < POOL_NODES)
        begin
            n = link_t'(fresh_next);
            fresh_next++;
        end
        else
        begin
            return 1'b0;
        end
        key_store[n]     = k;
        payload_store[n] = v;
        in_use[n]        = 1'b1;

        // With no cursor the list is empty or the node goes after the tail
        at = cursor_at;
        if (!is_live(at))
        begin
            at         = list_tail;
            before_cur = 1'b0;
        end

        if (!is_live(at))
        begin
            pred_link[n] = NONE_NODE;
            succ_link[n] = NONE_NODE;
            list_head    = n;
            list_tail    = n;
        end
        else if (!before_cur)
        begin
            nb            = succ_link[at];
            pred_link[n]  = at;
            succ_link[n]  = nb;
            succ_link[at] = n;
            if (is_live(nb))
            begin
                pred_link[nb] = n;
            end
            else
            begin
                list_tail = n;
            end
        end
        else
        begin
            nb            = pred_link[at];
            succ_link[n]  = at;
            pred_link[n]  = nb;
            pred_link[at] = n;
            if (is_live(nb))
            begin
                succ_link[nb] = n;
            end
            else
            begin
                list_head = n;
            end
        end
        cursor_at = n;
        node_count++;
        return 1'b1;
    endfunction

    function automatic bit remove_node(link_t c);
        link_t p;
        link_t x;
        bit    has_p;
        bit    has_x;
        if (!is_live(c))
        begin
            return 1'b0;
        end
        p     = pred_link[c];
        x     = succ_link[c];
        has_p = is_live(p);
        has_x = is_live(x);
        if (has_p)
        begin
            succ_link[p] = x;
        end
        else
        begin
            list_head = has_x ? x : NONE_NODE;
        end
        if (has_x)
        begin
            pred_link[x] = p;
        end
        else
        begin
            list_tail = has_p ? p : NONE_NODE;
        end
        // Cursor prefers the following node, then the preceding one
        cursor_at = has_x ? x : (has_p ? p : NONE_NODE);
        in_use[c] = 1'b0;
        if (spare_depth < POOL_NODES)
        begin
            spare_stack[spare_depth] = c;
            spare_depth++;
        end
        if (node_count > 0)
        begin
            node_count--;
        end
        return 1'b1;
    endfunction

    function automatic result_t apply_list_op(logic [MODE_BITS-1:0] mode,
                                              logic [HANDLE_BITS-1:0] handle,
                                              logic [KEY_BITS-1:0] k,
                                              logic [PAYLOAD_BITS-1:0] v);
        result_t res;
        bit      done;
        bit      present;
        link_t   h;
        done = 1'b0;
        h    = link_t'(handle);
        unique case (mode)
            MODE_INS_AFTER:  done = insert_node(1'b0, k, v);
            MODE_INS_BEFORE: done = insert_node(1'b1, k, v);
            MODE_REM_CURSOR: done = remove_node(cursor_at);
            MODE_REM_HANDLE: done = remove_node(h);
            MODE_SELECT:
            begin
                if (is_live(h))
                begin
                    cursor_at = h;
                    done      = 1'b1;
                end
            end
            MODE_PREV:
            begin
                if (is_live(cursor_at))
                begin
                    if (is_live(pred_link[cursor_at]))
                    begin
                        cursor_at = pred_link[cursor_at];
                        done      = 1'b1;
                    end
                end
            end
            MODE_NEXT:
            begin
                if (is_live(cursor_at))
                begin
                    if (is_live(succ_link[cursor_at]))
                    begin
                        cursor_at = succ_link[cursor_at];
                        done      = 1'b1;
                    end
                end
            end
            MODE_FIRST:
            begin
                cursor_at = is_live(list_head) ? list_head : NONE_NODE;
                done      = is_live(cursor_at);
            end
            MODE_LAST:
            begin
                cursor_at = is_live(list_tail) ? list_tail : NONE_NODE;
                done      = is_live(cursor_at);
            end
            MODE_READ:       done = is_live(cursor_at);
            default:         done = 1'b0;
        endcase

        present             = is_live(cursor_at);
        res.ok              = done;
        res.cursor_present  = present;
        res.cursor_index    = present ? cursor_at[INDEX_BITS-1:0] : '0;
        res.cursor_key      = present ? key_store[cursor_at] : '0;
        res.cursor_payload  = present ? payload_store[cursor_at] : '0;
        res.node_total      = TOTAL_BITS'(node_count);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_seen, name, got, want));
        end
    endtask

    // Drive the input stream; hold an offered transfer until it is taken
    always @(negedge clk)
    begin : drive_requests
        list_req_t req;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (offered_count == taken_count)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                req = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_TDATA_BITS'({req.payload, req.key, req.handle});
                s_axis_tuser  <= req.mode;
                offered_count <= offered_count + 1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started by the stimulus
    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= RX_HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= (hold_left == 0) &&
                             ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Check results first, then predict from the request taken at this edge
    always @(posedge clk)
    begin : watch_streams
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[RESULT_BITS-1:0]);
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result transfer with nothing expected");
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("ok", got.ok, want.ok);
                    check_field("cursor_present", got.cursor_present, want.cursor_present);
                    check_field("cursor_index", got.cursor_index, want.cursor_index);
                    check_field("cursor_key", got.cursor_key, want.cursor_key);
                    check_field("cursor_payload", got.cursor_payload, want.cursor_payload);
                    check_field("node_total", got.node_total, want.node_total);
                    check_field("zero fill", m_axis_tdata[OUT_TDATA_BITS-1:RESULT_BITS], '0);
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(apply_list_op(
                    s_axis_tuser,
                    s_axis_tdata[HANDLE_BITS-1:0],
                    s_axis_tdata[HANDLE_BITS +: KEY_BITS],
                    s_axis_tdata[HANDLE_BITS + KEY_BITS +: PAYLOAD_BITS]));
                taken_count <= taken_count + 1;
            end
        end
    end

    function automatic list_req_t make_req(logic [MODE_BITS-1:0] mode,
                                           logic [HANDLE_BITS-1:0] handle,
                                           logic [KEY_BITS-1:0] k,
                                           logic [PAYLOAD_BITS-1:0] v);
        list_req_t r;
        r.mode    = mode;
        r.handle  = handle;
        r.key     = k;
        r.payload = v;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            return '0;
        end
        if (pick == 1)
        begin
            return '1;
        end
        return $urandom;
    endfunction

    function automatic list_req_t random_req(int ins_pct);
        list_req_t r;
        int        pick;
        // Low handles are the ones most likely to be live
        r.handle  = ($urandom_range(0, 1) != 0) ? HANDLE_BITS'($urandom_range(0, 31))
                                                : HANDLE_BITS'($urandom);
        r.key     = rand_word();
        r.payload = rand_word();
        if ($urandom_range(0, 99) < ins_pct)
        begin
            r.mode = ($urandom_range(0, 1) != 0) ? MODE_INS_AFTER : MODE_INS_BEFORE;
            return r;
        end
        pick = $urandom_range(0, 29);
        if (pick < 4)
            r.mode = MODE_REM_CURSOR;
        else if (pick < 8)
            r.mode = MODE_REM_HANDLE;
        else if (pick < 12)
            r.mode = MODE_SELECT;
        else if (pick < 17)
            r.mode = MODE_PREV;
        else if (pick < 22)
            r.mode = MODE_NEXT;
        else if (pick < 24)
            r.mode = MODE_FIRST;
        else if (pick < 26)
            r.mode = MODE_LAST;
        else if (pick < 28)
            r.mode = MODE_READ;
        else
            r.mode = MODE_BITS'(MODE_READ) + MODE_BITS'($urandom_range(1, 6));
        return r;
    endfunction

    task automatic queue_random(input int count, input int ins_pct);
        repeat (count)
        begin
            pending_reqs.push_back(random_req(ins_pct));
        end
    endtask

    // Wait until every request is taken and every result is back
    task automatic wait_for_drain();
        @(negedge clk);
        while (pending_reqs.size() != 0 || offered_count != taken_count ||
               expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic run_phase(input int count, input int ins_pct,
                             input int send_idle, input int recv_stall);
        sender_idle_pct    = send_idle;
        receiver_stall_pct = recv_stall;
        queue_random(count, ins_pct);
        wait_for_drain();
    endtask

    initial
    begin : stimulus
        int pick;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: every read and move fails, unknown modes do nothing
        pending_reqs.push_back(make_req(MODE_READ, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_FIRST, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_LAST, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_PREV, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_NEXT, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_REM_CURSOR, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_REM_HANDLE, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_SELECT, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_SELECT, 8'hFF, '0, '0));
        pending_reqs.push_back(make_req(MODE_BITS'(MODE_READ) + 4'd6, 8'hFF, '1, '1));
        pending_reqs.push_back(make_req(MODE_BITS'(MODE_READ) + 4'd1, 8'h00, '0, '0));
        // Build three nodes, walk past both ends
        pending_reqs.push_back(make_req(MODE_INS_BEFORE, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_INS_AFTER, 8'h00, '1, '1));
        pending_reqs.push_back(make_req(MODE_INS_BEFORE, 8'h00, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
        pending_reqs.push_back(make_req(MODE_PREV, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_PREV, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_NEXT, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_NEXT, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_NEXT, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_FIRST, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_LAST, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_SELECT, 8'h02, '0, '0));
        // Free handle refused, then tear down and reuse freed nodes
        pending_reqs.push_back(make_req(MODE_REM_HANDLE, 8'hFF, '0, '0));
        pending_reqs.push_back(make_req(MODE_REM_HANDLE, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_REM_CURSOR, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_REM_CURSOR, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_REM_CURSOR, 8'h00, '0, '0));
        pending_reqs.push_back(make_req(MODE_INS_AFTER, 8'h00, 32'h0123_4567, 32'h89AB_CDEF));
        wait_for_drain();

        run_phase(330, 45, 0, 0);

        // Fill the pool past its end while the receiver holds off
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_requests      = hold_requests + 1;
        repeat (270)
        begin
            pending_reqs.push_back(make_req(
                ($urandom_range(0, 1) != 0) ? MODE_INS_AFTER : MODE_INS_BEFORE,
                HANDLE_BITS'($urandom), rand_word(), rand_word()));
        end
        queue_random(40, 50);
        // Drain the list, mostly from the cursor
        repeat (300)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 17)
                pending_reqs.push_back(make_req(MODE_REM_CURSOR, HANDLE_BITS'($urandom),
                                                rand_word(), rand_word()));
            else if (pick == 17)
                pending_reqs.push_back(make_req(MODE_PREV, HANDLE_BITS'($urandom), '0, '0));
            else if (pick == 18)
                pending_reqs.push_back(make_req(MODE_FIRST, HANDLE_BITS'($urandom), '0, '0));
            else
                pending_reqs.push_back(make_req(MODE_REM_HANDLE, HANDLE_BITS'($urandom),
                                                '0, '0));
        end
        wait_for_drain();

        run_phase(240, 40, 87, 0);
        run_phase(240, 35, 0, 87);
        run_phase(240, 35, 9, 9);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
